// ===== src/stkc_pkg.sv =====
`timescale 1ns / 1ps
package stkc_pkg;
	localparam logic [3:0] OP_PUSH  = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_OUT   = 4'd4;
	localparam logic [3:0] OP_MUL   = 4'd5;
	localparam logic [3:0] OP_POW   = 4'd6;
	localparam logic [3:0] OP_SQRT  = 4'd7;
	localparam logic [3:0] OP_RESET = 4'd8;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_UNDER  = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_DIVZ   = 3'd3;
	localparam logic [2:0] ST_DOMAIN = 3'd4;
	localparam logic [2:0] ST_OVF    = 3'd5;

	localparam logic [1:0] FN_DIV  = 2'd0;
	localparam logic [1:0] FN_SQRT = 2'd1;
	localparam logic [1:0] FN_POW  = 2'd2;

	// request to the iterative unit
	typedef struct packed {
		logic        start;
		logic [1:0]  fn;
		logic [31:0] a;
		logic [31:0] b;
	} stkc_req_t;

	// answer from the iterative unit
	typedef struct packed {
		logic        done;
		logic [31:0] result;
		logic        ovf;
	} stkc_rsp_t;
endpackage

// ===== src/stack_calculator_core.sv =====
`timescale 1ns / 1ps
// Integer stack calculator: one command per transaction, one result per command.
// The stack lives in a single-port synchronous memory; a command reads the top
// (and second) entry one at a time, then writes its result back, if any. PUSH,
// RESET, and commands refused for an empty or full stack go straight from the
// first read to the result. ADD, SUB, MUL, OUT, unused codes, a zero divisor,
// a negative square root and the POW shortcuts use two memory reads and an
// execute step. DIV adds 32 quotient steps in the shared iterative unit, SQRT
// 16 root bits, and POW one multiply per exponent step, stopping early once the
// result saturates. One command is in flight at a time; the result sits in an
// output register, so the next command may be accepted while it waits to be
// taken. A stalled result holds back only the final step of the next command.
module stack_calculator_core #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         op,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [2:0]         status
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic        rd_en;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_data;

	logic [2:0]  state_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]  op_q;
	logic [31:0] opd_q;
	logic [31:0] top_q;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic [2:0]  status_q;
	logic [31:0] res_q;
	logic [2:0]  rst_q;
	logic        bin;
	logic        una;

	stkc_pkg::stkc_req_t req;
	stkc_pkg::stkc_rsp_t rsp;

	stkc_iter u_iter (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign bin = (op_q == stkc_pkg::OP_ADD) || (op_q == stkc_pkg::OP_SUB) ||
		(op_q == stkc_pkg::OP_DIV) || (op_q == stkc_pkg::OP_MUL);
	assign una = (op_q == stkc_pkg::OP_OUT) || (op_q == stkc_pkg::OP_POW) ||
		(op_q == stkc_pkg::OP_SQRT) || (op_q > stkc_pkg::OP_RESET);

	// stack memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// memory port and unit requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(cnt_q - CW'(1));
		wr_en   = 1'b0;
		wr_addr = AW'(cnt_q);
		wr_data = opd_q;
		req     = '0;
		unique case (state_q)
			S_RD1: rd_en = 1'b1;
			S_RD2: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cnt_q - CW'(2));
			end
			S_EXEC: begin
				if (op_q == stkc_pkg::OP_DIV && top_q != 32'd0) begin
					req.start = 1'b1;
					req.fn    = stkc_pkg::FN_DIV;
					req.a     = rd_q;
					req.b     = top_q;
				end else if (op_q == stkc_pkg::OP_SQRT && !top_q[31]) begin
					req.start = 1'b1;
					req.fn    = stkc_pkg::FN_SQRT;
					req.a     = top_q;
				end else if (op_q == stkc_pkg::OP_POW && opd_q != 32'd0 &&
						!opd_q[31] && top_q != 32'd0 && top_q != 32'd1 &&
						top_q != 32'hffffffff) begin
					req.start = 1'b1;
					req.fn    = stkc_pkg::FN_POW;
					req.a     = top_q;
					req.b     = opd_q;
				end
			end
			S_DONE: begin
				wr_en   = (rst_q == stkc_pkg::ST_OK || rst_q == stkc_pkg::ST_OVF) &&
					(op_q != stkc_pkg::OP_OUT) && (op_q != stkc_pkg::OP_RESET) &&
					(op_q <= stkc_pkg::OP_SQRT);
				wr_data = (op_q == stkc_pkg::OP_PUSH) ? opd_q : res_q;
				wr_addr = bin ? AW'(cnt_q - CW'(2)) :
					(op_q == stkc_pkg::OP_PUSH) ? AW'(cnt_q) : AW'(cnt_q - CW'(1));
			end
			default: ;
		endcase
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q  <= op;
						opd_q <= operand;
						res_q <= '0;
						rst_q <= stkc_pkg::ST_OK;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					if (op_q == stkc_pkg::OP_PUSH) begin
						if (cnt_q >= CW'(STACK_DEPTH)) rst_q <= stkc_pkg::ST_FULL;
						state_q <= S_DONE;
					end else if (op_q == stkc_pkg::OP_RESET) begin
						state_q <= S_DONE;
					end else if (bin && cnt_q < CW'(2)) begin
						rst_q   <= stkc_pkg::ST_UNDER;
						state_q <= S_DONE;
					end else if (una && cnt_q == '0) begin
						if (op_q <= stkc_pkg::OP_SQRT) rst_q <= stkc_pkg::ST_UNDER;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					top_q   <= rd_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					unique case (op_q)
						stkc_pkg::OP_ADD: res_q <= rd_q + top_q;
						stkc_pkg::OP_SUB: res_q <= rd_q - top_q;
						stkc_pkg::OP_MUL: res_q <= 32'(rd_q * top_q);
						stkc_pkg::OP_OUT: res_q <= top_q;
						stkc_pkg::OP_DIV: begin
							if (top_q == 32'd0) rst_q <= stkc_pkg::ST_DIVZ;
							else state_q <= S_WAIT;
						end
						stkc_pkg::OP_SQRT: begin
							if (top_q[31]) rst_q <= stkc_pkg::ST_DOMAIN;
							else state_q <= S_WAIT;
						end
						stkc_pkg::OP_POW: begin
							if (opd_q[31]) begin
								if (top_q == 32'd0) rst_q <= stkc_pkg::ST_DOMAIN;
								else if (top_q == 32'd1) res_q <= 32'd1;
								else if (top_q == 32'hffffffff)
									res_q <= opd_q[0] ? 32'hffffffff : 32'd1;
								else res_q <= 32'd0;
							end else if (opd_q == 32'd0) res_q <= 32'd1;
							else if (top_q == 32'd0 || top_q == 32'd1) res_q <= top_q;
							else if (top_q == 32'hffffffff)
								res_q <= opd_q[0] ? 32'hffffffff : 32'd1;
							else state_q <= S_WAIT;
						end
						default: res_q <= top_q;
					endcase
				end
				S_WAIT: begin
					if (rsp.done) begin
						res_q   <= rsp.result;
						if (rsp.ovf) rst_q <= stkc_pkg::ST_OVF;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= rst_q;
						if (rst_q == stkc_pkg::ST_OK || rst_q == stkc_pkg::ST_OVF) begin
							value_q <= (op_q == stkc_pkg::OP_PUSH) ? opd_q : res_q;
							if (op_q == stkc_pkg::OP_PUSH) cnt_q <= cnt_q + CW'(1);
							else if (op_q == stkc_pkg::OP_RESET) cnt_q <= '0;
							else if (bin || op_q == stkc_pkg::OP_OUT)
								cnt_q <= cnt_q - CW'(1);
						end else begin
							value_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/stkc_iter.sv =====
`timescale 1ns / 1ps
// shared multi-cycle unit: signed divide, integer square root, saturating power
module stkc_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  stkc_pkg::stkc_req_t req,
	output stkc_pkg::stkc_rsp_t rsp
);
	logic        busy_q;
	logic [1:0]  fn_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic        qneg_q;
	logic [31:0] base_q;
	logic [32:0] mag_q;
	logic [31:0] exp_q;
	logic        pneg_q;
	logic        ovf_q;
	logic        done_q;
	logic [31:0] res_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic [31:0] sq_t;
	logic [63:0] sq_sq;
	logic [63:0] pw_prod;
	logic [32:0] pw_lim;
	logic [31:0] a_abs;
	logic [31:0] b_abs;

	assign a_abs = req.a[31] ? 32'(-req.a) : req.a;
	assign b_abs = req.b[31] ? 32'(-req.b) : req.b;

	// restoring division step
	assign rem_sh  = {rem_q[31:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	// square root trial bit
	assign sq_t    = quo_q | (32'd1 << cnt_q[3:0]);
	assign sq_sq   = 64'(sq_t) * 64'(sq_t);
	// power step
	assign pw_prod = 64'(mag_q[31:0]) * 64'(base_q);
	assign pw_lim  = pneg_q ? 33'h080000000 : 33'h07fffffff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				fn_q   <= req.fn;
				ovf_q  <= 1'b0;
				unique case (req.fn)
					stkc_pkg::FN_DIV: begin
						quo_q  <= a_abs;
						rem_q  <= '0;
						dvs_q  <= b_abs;
						qneg_q <= req.a[31] ^ req.b[31];
						cnt_q  <= 6'd32;
					end
					stkc_pkg::FN_SQRT: begin
						quo_q <= '0;
						dvs_q <= req.a;
						cnt_q <= 6'd15;
					end
					default: begin
						base_q <= a_abs;
						pneg_q <= req.a[31] & req.b[0];
						mag_q  <= 33'd1;
						exp_q  <= req.b;
						cnt_q  <= 6'd0;
					end
				endcase
			end else if (busy_q) begin
				unique case (fn_q)
					stkc_pkg::FN_DIV: begin
						if (!rem_sub[32]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == 6'd1) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= qneg_q ?
								32'(-{quo_q[30:0], !rem_sub[32]}) :
								{quo_q[30:0], !rem_sub[32]};
						end
					end
					stkc_pkg::FN_SQRT: begin
						if (sq_sq <= 64'(dvs_q)) quo_q <= sq_t;
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == 6'd0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= (sq_sq <= 64'(dvs_q)) ? sq_t : quo_q;
						end
					end
					default: begin
						// magnitude stays at most 2^31 between steps
						if (exp_q == 32'd0 || cnt_q == 6'd40) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= pneg_q ? 32'(-mag_q[31:0]) : mag_q[31:0];
						end else if (pw_prod > 64'(pw_lim)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							ovf_q  <= 1'b1;
							res_q  <= pneg_q ? 32'h80000000 : 32'h7fffffff;
						end else begin
							mag_q <= pw_prod[32:0];
							exp_q <= exp_q - 32'd1;
							cnt_q <= cnt_q + 6'd1;
						end
					end
				endcase
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;
	assign rsp.ovf    = ovf_q;
endmodule
